@@ hdl/bpa_pkg.sv @@
// Shared types, codes and constants of the bitmap page allocator.
package bpa_pkg;

  // Default number of physical pages covered by the free map
  localparam int MAP_PAGES_DEF = 512;

  // Bits per free map word; page p lives in word p / WORD_BITS, bit p % WORD_BITS
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Field widths of the transactions and registers
  localparam int OP_W     = 2;
  localparam int PAGE_W   = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;
  localparam int CFG_W    = 10;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_FIRST_PAGE = 1'b0;
  localparam logic REG_PAGE_LIMIT = 1'b1;
  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 10'd1;
  localparam logic [CFG_W-1:0] PAGE_LIMIT_RST = 10'd512;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

  // Request and response transactions
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_out;
    logic [COUNT_W-1:0]  free_count;
  } rsp_t;

  // Datapath command fields
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_INIT,
    WR_ALLOC,
    WR_FREE
  } wr_kind_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_INIT
  } cnt_op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_REQ,
    RD_IDX
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                idx_clr;
    logic                idx_inc;
    rd_sel_t             rd_sel;
    wr_kind_t            wr_kind;
    cnt_op_t             cnt_op;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
    logic                out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic in_range;
    logic idx_last;
    logic idx_end;
    logic word_hit;
    logic bit_set;
  } dp_stat_t;

endpackage

@@ hdl/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: configuration registers and core.
//
//   port group   direction  handshake            payload
//   req          in         req_valid/req_stall  req_t   (operation, page)
//   rsp          out        rsp_valid/rsp_stall  rsp_t   (status, page_out, free_count)
//   config       in         psel/penable/pready  first_page, page_limit
//
// One transaction at a time. With W = ceil(MAP_PAGES/32) map words (16 by default):
// init sweeps all W words, allocate scans word-serially via the map RAM read port,
// free reads the page's word; an out-of-range free, an empty allocate and the unused
// code skip the map. A clearing pass after reset zeroes the map with req_stall high.
// A finished result waits in the output register while the next request is taken.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] first_page;
  logic [CFG_W-1:0] page_limit;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= FIRST_PAGE_RST;
      page_limit <= PAGE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIRST_PAGE: first_page <= pwdata[CFG_W-1:0];
        REG_PAGE_LIMIT: page_limit <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[2])
      REG_FIRST_PAGE: prdata = DATA_W'(first_page);
      REG_PAGE_LIMIT: prdata = DATA_W'(page_limit);
      default:        prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_operation (req.operation),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  bpa_dpath #(
    .MAP_PAGES (MAP_PAGES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .first_page (first_page),
    .page_limit (page_limit),
    .cmd        (cmd),
    .stat       (stat),
    .rsp        (rsp)
  );

endmodule

@@ hdl/bpa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bpa_ctrl.sv @@
// Controller state machine of the bitmap page allocator.
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_operation,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_FREE_CHK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_kind = WR_CLEAR;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_operation)
            OP_INIT: begin
              state_next = S_INIT;
            end
            OP_ALLOC: begin
              if (stat.count_zero) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NO_FREE;
                state_next     = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_FREE: begin
              if (!stat.in_range) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OUT_OF_RANGE;
                state_next     = S_DONE;
              end else begin
                cmd.rd_sel = RD_REQ;
                state_next = S_FREE_CHK;
              end
            end
            default: begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd.wr_kind = WR_INIT;
        if (stat.idx_last) begin
          cmd.idx_clr    = 1'b1;
          cmd.cnt_op     = CNT_INIT;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        // Words stream out of the RAM one a cycle; stop at the first non-empty one
        if (stat.word_hit) begin
          cmd.wr_kind    = WR_ALLOC;
          cmd.cnt_op     = CNT_DEC;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_found  = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_next     = S_DONE;
        end else if (stat.idx_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_FREE;
          cmd.idx_clr    = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.rd_sel  = RD_IDX;
          cmd.idx_inc = 1'b1;
        end
      end
      S_FREE_CHK: begin
        cmd.res_set = 1'b1;
        if (stat.bit_set) begin
          cmd.res_status = ST_ALREADY_FREE;
        end else begin
          cmd.wr_kind    = WR_FREE;
          cmd.cnt_op     = CNT_INC;
          cmd.res_status = ST_OK;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/bpa_dpath.sv @@
// Datapath of the bitmap page allocator: free map RAM, counters and result registers.
module bpa_dpath
  import bpa_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic [CFG_W-1:0] first_page,
  input  logic [CFG_W-1:0] page_limit,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output rsp_t             rsp
);

  localparam int MAP_WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = AW + 1;
  localparam int NW        = AW + BIT_W;
  localparam int CW        = ((NW > CFG_W) ? NW : CFG_W) + 1;
  localparam logic [CW-1:0] MAP_PAGES_C = CW'(MAP_PAGES);
  localparam logic [IW-1:0] LAST_IDX    = IW'(MAP_WORDS - 1);
  localparam logic [IW-1:0] END_IDX     = IW'(MAP_WORDS);

  // Registers
  logic [IW-1:0]       idx;
  logic [AW-1:0]       data_idx;
  logic                rd_vld;
  logic [PAGE_W-1:0]   page_q;
  logic [COUNT_W-1:0]  free_pages;
  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_page;

  // Combinational
  logic [CW-1:0]        first_c;
  logic [CW-1:0]        limit_c;
  logic [CW-1:0]        lim_eff;
  logic [CW-1:0]        req_page_c;
  logic [CW-1:0]        page_c;
  logic [CW-1:0]        page_b;
  logic [AW-1:0]        req_word;
  logic [AW-1:0]        page_word;
  logic [BIT_W-1:0]     page_bit;
  logic [COUNT_W-1:0]   init_count;
  logic [WORD_BITS-1:0] init_mask;
  logic [WORD_BITS-1:0] lowbit;
  logic [BIT_W-1:0]     enc;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Effective page range
  assign first_c    = CW'(first_page);
  assign limit_c    = CW'(page_limit);
  assign lim_eff    = (limit_c < MAP_PAGES_C) ? limit_c : MAP_PAGES_C;
  assign init_count = (lim_eff > first_c) ? COUNT_W'(lim_eff - first_c) : '0;

  // Page addressing for the incoming and the held request
  assign req_page_c = CW'(req.page);
  assign req_word   = req_page_c[NW-1:BIT_W];
  assign page_c     = CW'(page_q);
  assign page_word  = page_c[NW-1:BIT_W];
  assign page_bit   = page_q[BIT_W-1:0];

  // Free bits of the word under the sweep for an init
  always_comb begin
    init_mask = '0;
    page_b    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      page_b       = CW'({idx[AW-1:0], BIT_W'(b)});
      init_mask[b] = (page_b >= first_c) && (page_b < lim_eff);
    end
  end

  // Lowest set bit of the word just read and its position
  assign lowbit = ram_rdata & (~ram_rdata + WORD_BITS'(1));
  always_comb begin
    enc = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowbit[b]) begin
        enc = enc | BIT_W'(b);
      end
    end
  end

  // RAM read port
  assign ram_re    = (cmd.rd_sel != RD_NONE);
  assign ram_raddr = (cmd.rd_sel == RD_REQ) ? req_word : idx[AW-1:0];

  // RAM write port
  assign ram_we = (cmd.wr_kind != WR_NONE);
  always_comb begin
    unique case (cmd.wr_kind)
      WR_CLEAR: begin
        ram_waddr = idx[AW-1:0];
        ram_wdata = '0;
      end
      WR_INIT: begin
        ram_waddr = idx[AW-1:0];
        ram_wdata = init_mask;
      end
      WR_ALLOC: begin
        ram_waddr = data_idx;
        ram_wdata = ram_rdata & ~lowbit;
      end
      WR_FREE: begin
        ram_waddr = page_word;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << page_bit);
      end
      default: begin
        ram_waddr = '0;
        ram_wdata = '0;
      end
    endcase
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  assign stat.count_zero = (free_pages == '0);
  assign stat.in_range   = (req_page_c >= first_c) && (req_page_c < lim_eff);
  assign stat.idx_last   = (idx == LAST_IDX);
  assign stat.idx_end    = (idx == END_IDX);
  assign stat.word_hit   = rd_vld && (ram_rdata != '0);
  assign stat.bit_set    = ram_rdata[page_bit];

  // Sweep index, read tracking and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_vld     <= 1'b0;
      free_pages <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      rd_vld <= ram_re;
      case (cmd.cnt_op)
        CNT_INC:  free_pages <= free_pages + COUNT_W'(1);
        CNT_DEC:  free_pages <= free_pages - COUNT_W'(1);
        CNT_INIT: free_pages <= init_count;
        default:  free_pages <= free_pages;
      endcase
    end
  end

  // Hold the request page, the read address and the result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q <= req.page;
    end
    if (ram_re) begin
      data_idx <= ram_raddr;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_page   <= cmd.res_found ? PAGE_W'({data_idx, enc}) : '0;
    end
    if (cmd.out_load) begin
      rsp.status     <= res_status;
      rsp.page_out   <= res_page;
      rsp.free_count <= free_pages;
    end
  end

endmodule

@@ hdl/bpa_checker.sv @@
// Port-level checks of the bitmap page allocator, bound to the top level.
module bpa_checker
  import bpa_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF
) (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Reset drops any pending response and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_stall)
    else $error("response pending or requests taken right after reset");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Only a successful transaction may carry a page number
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.page_out == '0))
    else $error("failed transaction returned a page");

  // The free count never exceeds the pages present
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.free_count) <= 32'(MAP_PAGES)))
    else $error("free count above page capacity");

endmodule

bind bitmap_page_allocator bpa_checker #(
  .MAP_PAGES (MAP_PAGES)
) u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ bench/tb_bitmap_page_allocator.sv @@
// Self-checking testbench for the bitmap page allocator.
module tb_bitmap_page_allocator
  import bpa_pkg::*;
();

  // The request field has no code for the spare operation value
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Longest allocate scan with some margin, in cycles
  localparam int SETTLE_CYCLES = 24;
  // Length of the long response hold-off, in cycles
  localparam int HOLD_CYCLES   = 300;

  // Predicts allocator responses and checks them in order
  class page_map_scoreboard;
    logic [MAP_PAGES_DEF-1:0] free_bits;
    int unsigned              free_total;
    int unsigned              first_reg;
    int unsigned              limit_reg;
    rsp_t                     due_q[$];
    int                       errors;

    function new();
      free_bits  = '0;
      free_total = 0;
      first_reg  = FIRST_PAGE_RST;
      limit_reg  = PAGE_LIMIT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, int unsigned value);
      if (idx == REG_FIRST_PAGE) begin
        first_reg = value;
      end else begin
        limit_reg = value;
      end
    endfunction

    // Pages at or above this are never free
    function int unsigned top_page();
      return (limit_reg < MAP_PAGES_DEF) ? limit_reg : MAP_PAGES_DEF;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Apply one accepted request to the map and queue its response
    function void note_request(req_t r);
      rsp_t        due;
      int unsigned lim;
      int          p;
      int          pg;
      bit          found;
      lim   = top_page();
      pg    = int'(r.page);
      due   = '0;
      found = 1'b0;
      case (r.operation)
        OP_INIT: begin
          free_bits  = '0;
          free_total = 0;
          for (p = int'(first_reg); p < int'(lim); p++) begin
            free_bits[p] = 1'b1;
            free_total++;
          end
        end
        OP_ALLOC: begin
          // First fit: lowest numbered free page
          if (free_total != 0) begin
            for (p = 0; p < MAP_PAGES_DEF && !found; p++) begin
              if (free_bits[p]) begin
                found        = 1'b1;
                free_bits[p] = 1'b0;
                free_total--;
                due.page_out = p[PAGE_W-1:0];
              end
            end
          end
          due.status = found ? ST_OK : ST_NO_FREE;
        end
        OP_FREE: begin
          if (pg < int'(first_reg) || pg >= int'(lim)) begin
            due.status = ST_OUT_OF_RANGE;
          end else if (free_bits[pg]) begin
            due.status = ST_ALREADY_FREE;
          end else begin
            free_bits[pg] = 1'b1;
            free_total++;
          end
        end
        default: ;
      endcase
      due.free_count = free_total[COUNT_W-1:0];
      due_q.push_back(due);
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted response with the oldest prediction
    task check_response(rsp_t got);
      rsp_t due;
      if (due_q.size() == 0) begin
        report($sformatf("response with none outstanding: status %0d page %0d count %0d",
                         got.status, got.page_out, got.free_count));
        return;
      end
      due = due_q.pop_front();
      if (got.status !== due.status)
        report($sformatf("status %0d, predicted %0d", got.status, due.status));
      if (got.page_out !== due.page_out)
        report($sformatf("page_out %0d, predicted %0d", got.page_out, due.page_out));
      if (got.free_count !== due.free_count)
        report($sformatf("free_count %0d, predicted %0d", got.free_count, due.free_count));
    endtask
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  page_map_scoreboard sb = new();
  int tx_mode = 0;
  int rx_mode = 0;
  bit hold_request = 1'b0;

  bitmap_page_allocator u_top (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #15_000_000;
    $display("bitmap_page_allocator test failed");
    $finish;
  end

  // Gap length for either side: none, light or heavy idling
  function automatic int pick_gap(int mode);
    int k;
    k = $urandom_range(99, 0);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (k < 75) return 0;
      if (k < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
    end
    if (k < 40) return 0;
    if (k < 85) return $urandom_range(4, 1);
    return $urandom_range(40, 8);
  endfunction

  // Pick a page in the current range whose free bit matches, else any page
  function automatic logic [PAGE_W-1:0] pick_page(bit want_free);
    int lo;
    int hi;
    int p;
    lo = int'(sb.first_reg);
    hi = int'(sb.top_page());
    if (lo < hi) begin
      repeat (8) begin
        p = $urandom_range(hi - 1, lo);
        if (sb.free_bits[p] == want_free) return p[PAGE_W-1:0];
      end
    end
    p = $urandom_range(MAP_PAGES_DEF - 1, 0);
    return p[PAGE_W-1:0];
  endfunction

  // Offer one request, wait for acceptance, then idle for a while
  task automatic issue(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg);
    req_t r;
    int   gap;
    r.operation = op;
    r.page      = pg;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(r);
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted response has arrived
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access until pready
  task automatic cfg_write(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One random request, mostly well-formed traffic over the current range
  task automatic random_request();
    int                k;
    int                p;
    logic [PAGE_W-1:0] any_pg;
    k      = $urandom_range(99, 0);
    p      = $urandom_range(MAP_PAGES_DEF - 1, 0);
    any_pg = p[PAGE_W-1:0];
    if (k < 40)      issue(OP_ALLOC, any_pg);
    else if (k < 70) issue(OP_FREE, pick_page(1'b0));
    else if (k < 80) issue(OP_FREE, pick_page(1'b1));
    else if (k < 90) issue(OP_FREE, any_pg);
    else if (k < 95) issue(OP_INIT, any_pg);
    else             issue(OP_UNUSED, any_pg);
  endtask

  // Response side: check accepted transactions and stall at random
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && !rsp_stall) sb.check_response(rsp);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else begin
        stall_left = pick_gap(rx_mode);
      end
      rsp_stall <= (stall_left > 0);
    end
  end

  // Request side: directed cases, then phases of random traffic
  initial begin : stimulus
    int          ph;
    int          n;
    int          items;
    int unsigned f;
    int unsigned l;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, empty map: allocate, spare code, frees before any init; then init, allocates and frees
    issue(OP_ALLOC, 9'h1FF);
    issue(OP_UNUSED, 9'h1FF);
    issue(OP_FREE, 9'd0);
    issue(OP_FREE, 9'd5);
    issue(OP_FREE, 9'd5);
    issue(OP_INIT, 9'h000);
    issue(OP_ALLOC, 9'h000);
    issue(OP_ALLOC, 9'h0AA);
    issue(OP_FREE, 9'd1);
    issue(OP_FREE, 9'd511);
    issue(OP_ALLOC, 9'h155);
    issue(OP_FREE, 9'h0AA);

    // Whole map usable: page zero handed out with a zero page number
    drain();
    cfg_write(REG_FIRST_PAGE, 0);
    cfg_write(REG_PAGE_LIMIT, 512);
    issue(OP_FREE, 9'd0);
    issue(OP_INIT, 9'h000);
    issue(OP_ALLOC, 9'h000);
    issue(OP_FREE, 9'd0);
    issue(OP_FREE, 9'd0);

    // Zero limit: nothing free, every free out of range
    drain();
    cfg_write(REG_PAGE_LIMIT, 0);
    issue(OP_INIT, 9'h000);
    issue(OP_ALLOC, 9'h000);
    issue(OP_FREE, 9'd0);
    issue(OP_FREE, 9'd511);

    for (ph = 0; ph < 12; ph++) begin
      items = 128;
      case (ph)
        0: begin f = 512; l = 512; items = 30; end
        1: begin f = 511; l = 512; items = 30; end
        2: begin f = 300; l = 200; items = 30; end
        3: begin f = 0;   l = 33;  items = 30; end
        default: begin
          f = $urandom_range(480, 0);
          if ($urandom_range(7, 0) == 0) l = 512;
          else l = f + $urandom_range(40, 1);
          if (l > 512) l = 512;
        end
      endcase
      drain();
      cfg_write(REG_FIRST_PAGE, f);
      cfg_write(REG_PAGE_LIMIT, l);
      tx_mode = $urandom_range(2, 0);
      rx_mode = $urandom_range(2, 0);
      // Hold responses off for long while requests keep coming
      if (ph == 4) begin
        tx_mode      = 0;
        hold_request = 1'b1;
      end
      if (ph < 4 || $urandom_range(3, 0) != 0) issue(OP_INIT, 9'h000);
      for (n = 0; n < items; n++) begin
        // Pause mid-phase until the allocator has answered everything
        if (ph == 5 && n == items / 2) drain();
        random_request();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("bitmap_page_allocator test passed");
    end else begin
      $display("bitmap_page_allocator test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/bpa_dpath.sv
hdl/bitmap_page_allocator.sv
hdl/bpa_checker.sv
bench/tb_bitmap_page_allocator.sv
